// ===== src/mtl_pkg.sv =====
// ----------------------------------------------------------------------------
// mtl_pkg
// Shared constants, lane control bundle and tempering function for the
// multi-lane MT19937 generator.
// ----------------------------------------------------------------------------
package mtl_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned TABLE_WORDS = 624;
  localparam int unsigned SHIFT_DIST  = 397;
  localparam int unsigned FAR_WRAP    = TABLE_WORDS - SHIFT_DIST;
  localparam int unsigned ADDR_W      = $clog2(TABLE_WORDS);
  localparam int unsigned OUT_FIELDS  = 8;
  localparam int unsigned SEL_W       = 3;
  localparam int unsigned IN_DATA_W   = 40;
  localparam int unsigned OUT_DATA_W  = OUT_FIELDS * WORD_W;

  localparam logic [WORD_W-1:0] INIT_MULT  = 32'h6c078965;
  localparam logic [WORD_W-1:0] TWIST_XOR  = 32'h9908b0df;
  localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9d2c5680;
  localparam logic [WORD_W-1:0] TEMPER_C   = 32'hefc60000;
  localparam logic [WORD_W-1:0] UPPER_BIT  = 32'h80000000;
  localparam logic [WORD_W-1:0] LOWER_BITS = 32'h7fffffff;

  // input kind carried on tuser
  localparam logic FUNC_DRAW = 1'b0;
  localparam logic FUNC_SEED = 1'b1;

  // control bundle broadcast from the sequencer to every lane
  typedef struct packed {
    logic              seed_load;
    logic              seed_from_index;
    logic [WORD_W-1:0] seed_value;
    logic              seed_write;
    logic [ADDR_W-1:0] seed_addr;
    logic              prime;
    logic              twist_issue;
    logic [ADDR_W-1:0] twist_addr;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
  } ctl_t;

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ===== src/mersenne_twister_lanes.sv =====
// draw: the read state and then the load state register the result; the load waits for room on the output
// draw at read position zero: a prime state and a twist pass over all 624 words of every table come first
// seed: one table word per cycle through the lane multiplier, until all 624 words are written
// reset: synchronous; afterwards an init load and a seed pass seed lane k with k, input held off
// the result register frees the input side, so a new transaction is taken while
// a result still waits on the output
// ----------------------------------------------------------------------------
// mersenne_twister_lanes
// LANES independent MT19937 generators sharing one read position. Each lane
// keeps its 624-word table in its own RAM; a sequencer steps seeding, the
// in-place twist pass and the tempered read, and a merge stage packs the
// lane words into one output transaction.
// ----------------------------------------------------------------------------
module mersenne_twister_lanes #(
  parameter int unsigned LANES = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  // input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [mtl_pkg::IN_DATA_W-1:0]   s_tdata,   // lane_select[2:0], seed_value[34:3], zero pad
  input  logic                            s_tuser,   // func: 0 draw, 1 seed
  // output stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mtl_pkg::OUT_DATA_W-1:0]  m_tdata    // lane_0[31:0] .. lane_7[255:224]
);
  import mtl_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT_LOAD,
    ST_SEED,
    ST_IDLE,
    ST_PRIME,
    ST_TWIST,
    ST_READ,
    ST_LOAD
  } state_t;

  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(TABLE_WORDS - 1);

  state_t             state;
  logic [ADDR_W-1:0]  pos;       // shared read position
  logic [ADDR_W-1:0]  idx;       // seed word counter
  logic [ADDR_W-1:0]  tw_i;      // twist word counter
  logic [LANES-1:0]   mask;      // lanes being seeded

  logic [SEL_W-1:0]   lane_select;
  logic [WORD_W-1:0]  seed_value;
  logic               accept;
  logic               seed_ok;
  logic               draw_go;
  logic [LANES-1:0]   sel_dec;
  logic [LANES-1:0]   lane_en;
  logic [ADDR_W-1:0]  tw_nxt;
  logic [ADDR_W-1:0]  tw_far;
  logic               room;
  logic               load;
  ctl_t               ctl;
  logic [LANES-1:0][WORD_W-1:0] words;

  // field unpacking
  assign lane_select = s_tdata[SEL_W-1:0];
  assign seed_value  = s_tdata[SEL_W +: WORD_W];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // seeds for lanes that do not exist are dropped
  for (genvar k = 0; k < LANES; k++) begin : g_dec
    assign sel_dec[k] = (32'(lane_select) == k);
  end
  assign seed_ok = |sel_dec;
  assign draw_go = accept && (s_tuser == FUNC_DRAW);

  always_comb begin
    unique case (state)
      ST_INIT_LOAD: lane_en = '1;
      ST_IDLE:      lane_en = sel_dec;
      default:      lane_en = mask;
    endcase
  end

  // twist neighbors of word tw_i
  assign tw_nxt = (tw_i == LAST_IDX) ? '0 : tw_i + 1'b1;
  assign tw_far = (tw_i < ADDR_W'(FAR_WRAP)) ? tw_i + ADDR_W'(SHIFT_DIST)
                                             : tw_i - ADDR_W'(FAR_WRAP);

  assign load = (state == ST_LOAD) && room;

  // lane control
  always_comb begin
    ctl                 = '0;
    ctl.seed_load       = (state == ST_INIT_LOAD)
                       || (accept && (s_tuser == FUNC_SEED) && seed_ok);
    ctl.seed_from_index = (state == ST_INIT_LOAD);
    ctl.seed_value      = seed_value;
    ctl.seed_write      = (state == ST_SEED);
    ctl.seed_addr       = idx;
    ctl.prime           = (state == ST_PRIME);
    ctl.twist_issue     = (state == ST_TWIST);
    ctl.twist_addr      = tw_i;
    unique case (state)
      ST_TWIST: begin
        ctl.rd_addr_a = tw_nxt;
        ctl.rd_addr_b = tw_far;
      end
      ST_READ, ST_LOAD: begin
        ctl.rd_addr_a = pos;
        ctl.rd_addr_b = '0;
      end
      default: begin
        ctl.rd_addr_a = '0;
        ctl.rd_addr_b = '0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT_LOAD;
      pos   <= '0;
      idx   <= '0;
      tw_i  <= '0;
      mask  <= '1;
    end else begin
      unique case (state)
        ST_INIT_LOAD: begin
          mask  <= '1;
          idx   <= '0;
          state <= ST_SEED;
        end
        ST_SEED: begin
          idx <= idx + 1'b1;
          if (idx == LAST_IDX) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (s_tuser == FUNC_SEED) begin
              if (seed_ok) begin
                mask  <= sel_dec;
                idx   <= '0;
                pos   <= '0;
                state <= ST_SEED;
              end
            end else if (pos == '0) begin
              state <= ST_PRIME;
            end else begin
              state <= ST_READ;
            end
          end
        end
        ST_PRIME: begin
          tw_i  <= '0;
          state <= ST_TWIST;
        end
        ST_TWIST: begin
          tw_i <= tw_nxt;
          if (tw_i == LAST_IDX) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          if (room) begin
            pos   <= (pos == LAST_IDX) ? '0 : pos + 1'b1;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // generator lanes
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    mtl_lane #(
      .LANE_ID (k)
    ) u_lane (
      .clk  (clk),
      .rst  (rst),
      .ctl  (ctl),
      .en   (lane_en[k]),
      .word (words[k])
    );
  end

  // merge lane words into one output transaction
  mtl_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .words    (words),
    .load     (load),
    .room     (room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // read position never leaves the table
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= LAST_IDX)
    else $error("read position out of range");

  // a draw past position zero reads directly without twisting
  a_draw_no_twist: assert property (@(posedge clk) disable iff (rst)
    (draw_go && pos != '0) |=> state == ST_READ)
    else $error("draw skipped the direct read");

  // the twist pass hands over to the read after its last word
  a_twist_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TWIST && tw_i == LAST_IDX) |=> state == ST_READ)
    else $error("twist pass did not finish into read");

  // position only moves when a draw is loaded into the result register or a seed for an existing lane is accepted
  a_pos_hold: assert property (@(posedge clk) disable iff (rst)
    (!load && !ctl.seed_load) |=> $stable(pos))
    else $error("read position moved without cause");

  // seeding and twisting never share a cycle
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ctl.seed_write && ctl.twist_issue))
    else $error("seed and twist overlap");

endmodule

// ===== src/mtl_ram.sv =====
// ----------------------------------------------------------------------------
// mtl_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module mtl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ===== src/mtl_lane.sv =====
// ----------------------------------------------------------------------------
// mtl_lane
// One generator lane: state table, seeding recurrence, in-place twist
// datapath and output tempering.
// ----------------------------------------------------------------------------
module mtl_lane #(
  parameter int unsigned LANE_ID = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mtl_pkg::ctl_t                ctl,
  input  logic                         en,
  output logic [mtl_pkg::WORD_W-1:0]   word
);
  import mtl_pkg::*;

  logic [WORD_W-1:0] p;
  logic [WORD_W-1:0] p_mix;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] cur;
  logic [WORD_W-1:0] rd_a;
  logic [WORD_W-1:0] rd_b;
  logic [WORD_W-1:0] y;
  logic [WORD_W-1:0] twisted;
  logic              tw_wr;
  logic              prime_d;
  logic [ADDR_W-1:0] tw_wr_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;

  // seeding recurrence, one word per cycle
  assign p_mix = p ^ (p >> 30);
  assign prod  = p_mix * INIT_MULT;

  // twist of word i: cur = old t[i], rd_a = t[i+1], rd_b = t[i+397]
  assign y       = (cur & UPPER_BIT) | (rd_a & LOWER_BITS);
  assign twisted = rd_b ^ (y >> 1) ^ (y[0] ? TWIST_XOR : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      tw_wr   <= 1'b0;
      prime_d <= 1'b0;
    end else begin
      tw_wr   <= ctl.twist_issue;
      prime_d <= ctl.prime;
    end
  end

  always_ff @(posedge clk) begin
    tw_wr_addr <= ctl.twist_addr;
    if (prime_d || tw_wr) begin
      cur <= rd_a;
    end
    if (ctl.seed_load && en) begin
      p <= ctl.seed_from_index ? WORD_W'(LANE_ID) : ctl.seed_value;
    end else if (ctl.seed_write && en) begin
      p <= prod + {{(WORD_W-ADDR_W){1'b0}}, ctl.seed_addr} + 32'd1;
    end
  end

  assign wr_en   = (ctl.seed_write && en) || tw_wr;
  assign wr_addr = tw_wr ? tw_wr_addr : ctl.seed_addr;
  assign wr_data = tw_wr ? twisted : p;

  mtl_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_WORDS)
  ) u_table (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (ctl.rd_addr_a),
    .rd_data_a (rd_a),
    .rd_addr_b (ctl.rd_addr_b),
    .rd_data_b (rd_b)
  );

  assign word = temper(rd_a);

endmodule

// ===== src/mtl_merge.sv =====
// ----------------------------------------------------------------------------
// mtl_merge
// Output stage: packs the lane words into one result register.
// ----------------------------------------------------------------------------
module mtl_merge #(
  parameter int unsigned LANES = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [LANES-1:0][mtl_pkg::WORD_W-1:0] words,
  input  logic                                  load,
  output logic                                  room,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [mtl_pkg::OUT_DATA_W-1:0]        m_tdata
);
  import mtl_pkg::*;

  logic [OUT_DATA_W-1:0] packed_words;

  for (genvar k = 0; k < OUT_FIELDS; k++) begin : g_field
    if (k < LANES) begin : g_used
      assign packed_words[k*WORD_W +: WORD_W] = words[k];
    end else begin : g_zero
      assign packed_words[k*WORD_W +: WORD_W] = '0;
    end
  end

  assign room = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= packed_words;
    end
  end

endmodule
